>>> rtl/core/cssp_pkg.sv
// Shared types and constants for the CSS color string parser.
// No dependencies; used by every module of the block.
package cssp_pkg;

    localparam int unsigned NAME_COUNT = 4;
    localparam int unsigned NAME_SLOTS = 8;
    localparam int unsigned NIB_COUNT  = 6;

    localparam logic [7:0] HASH_CHAR  = 8'h23;
    localparam logic [7:0] OPAQUE     = 8'hFF;
    localparam logic [3:0] POS_SAT    = 4'd8;
    localparam logic [3:0] LAST_NIB   = 4'd6;
    localparam logic [3:0] SHORT_LEN  = 4'd4;
    localparam logic [3:0] LONG_LEN   = 4'd7;

    typedef enum logic [1:0] {
        SRC_FALLBACK  = 2'd0,
        SRC_SHORT_HEX = 2'd1,
        SRC_LONG_HEX  = 2'd2,
        SRC_NAMED     = 2'd3
    } source_t;

    // bit0 black, bit1 white, bit2 red, bit3 blue
    localparam logic [7:0] NAME_TEXT [NAME_COUNT][NAME_SLOTS] = '{
        '{8'h62, 8'h6C, 8'h61, 8'h63, 8'h6B, 8'h00, 8'h00, 8'h00},
        '{8'h77, 8'h68, 8'h69, 8'h74, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h72, 8'h65, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h62, 8'h6C, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{4'd5, 4'd5, 4'd3, 4'd4};
    localparam logic [7:0] NAME_RGB [NAME_COUNT][3] = '{
        '{8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF},
        '{8'hFF, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'hFF}
    };

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last;
        logic [7:0] fallback_red;
        logic [7:0] fallback_green;
        logic [7:0] fallback_blue;
        logic [7:0] fallback_alpha;
    } item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        source_t    source;
    } result_t;

endpackage

>>> rtl/core/cssp_in_stage.sv
// Input register for the CSS color string parser.
// Depends on cssp_pkg for the item type.
module cssp_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cssp_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output cssp_pkg::item_t item
);
    import cssp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

>>> rtl/core/cssp_scan.sv
// String tracking state and color decode for the CSS color string parser.
// Depends on cssp_pkg for tables, the item type and the result type.
module cssp_scan (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  cssp_pkg::item_t   item,
    output cssp_pkg::result_t result
);
    import cssp_pkg::*;

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic       hex_ok_reg;
    logic       hex_ok_next;
    logic [3:0] name_match_reg;
    logic [3:0] name_match_next;
    logic [3:0] nib_reg  [NIB_COUNT];
    logic [3:0] nib_next [NIB_COUNT];
    logic [3:0] pos_dec;
    logic [3:0] len;
    logic [4:0] hv;
    logic       found;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    assign pos_dec  = pos_reg - 4'd1;
    assign len      = pos_reg + 4'd1;
    assign pos_next = (pos_reg < POS_SAT) ? pos_reg + 4'd1 : pos_reg;
    assign hv       = hex_value(item.char_byte);

    always_comb begin
        nib_next    = nib_reg;
        hex_ok_next = hex_ok_reg;
        if (pos_reg == 4'd0) begin
            if (item.char_byte != HASH_CHAR) begin
                hex_ok_next = 1'b0;
            end
        end else if (pos_reg <= LAST_NIB) begin
            if (!hv[4]) begin
                hex_ok_next = 1'b0;
            end else begin
                nib_next[pos_dec[2:0]] = hv[3:0];
            end
        end else begin
            hex_ok_next = 1'b0;
        end
    end

    always_comb begin
        name_match_next = name_match_reg;
        for (int k = 0; k < NAME_COUNT; k++) begin
            if (pos_reg >= NAME_LEN[k] || NAME_TEXT[k][pos_reg[2:0]] != item.char_byte) begin
                name_match_next[k] = 1'b0;
            end
        end
    end

    always_comb begin
        result.red    = item.fallback_red;
        result.green  = item.fallback_green;
        result.blue   = item.fallback_blue;
        result.alpha  = item.fallback_alpha;
        result.source = SRC_FALLBACK;
        found         = 1'b0;
        if (hex_ok_next && len == SHORT_LEN) begin
            result.red    = {nib_next[0], nib_next[0]};
            result.green  = {nib_next[1], nib_next[1]};
            result.blue   = {nib_next[2], nib_next[2]};
            result.alpha  = OPAQUE;
            result.source = SRC_SHORT_HEX;
        end else if (hex_ok_next && len == LONG_LEN) begin
            result.red    = {nib_next[0], nib_next[1]};
            result.green  = {nib_next[2], nib_next[3]};
            result.blue   = {nib_next[4], nib_next[5]};
            result.alpha  = OPAQUE;
            result.source = SRC_LONG_HEX;
        end else begin
            for (int k = 0; k < NAME_COUNT; k++) begin
                if (!found && name_match_next[k] && len == NAME_LEN[k]) begin
                    found         = 1'b1;
                    result.red    = NAME_RGB[k][0];
                    result.green  = NAME_RGB[k][1];
                    result.blue   = NAME_RGB[k][2];
                    result.alpha  = OPAQUE;
                    result.source = SRC_NAMED;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= 4'd0;
            hex_ok_reg     <= 1'b1;
            name_match_reg <= 4'hF;
        end else if (advance) begin
            if (item.last) begin
                pos_reg        <= 4'd0;
                hex_ok_reg     <= 1'b1;
                name_match_reg <= 4'hF;
            end else begin
                pos_reg        <= pos_next;
                hex_ok_reg     <= hex_ok_next;
                name_match_reg <= name_match_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            nib_reg <= nib_next;
        end
    end
endmodule

>>> rtl/core/cssp_out_stage.sv
// Result register for the CSS color string parser.
// Depends on cssp_pkg for the result type.
module cssp_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  cssp_pkg::result_t result,
    output logic             busy,
    output logic             m_valid,
    input  logic             m_ready,
    output cssp_pkg::result_t m_result
);
    import cssp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign busy       = valid_reg && !m_ready;
    assign valid_next = load || busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;
endmodule

>>> rtl/core/css_color_string_parser_unit.sv
// Top level of the CSS color string parser: input register, scan logic, result register.
// Depends on cssp_pkg, cssp_in_stage, cssp_scan and cssp_out_stage.
//
//   channel  | direction | handshake         | payload
//   s_       | in        | s_valid / s_ready | char_byte, last, fallback_red/green/blue/alpha
//   m_       | out       | m_valid / m_ready | red, green, blue, alpha, source
//
// One byte is taken per cycle unless a last byte is held back by a stalled result.
// A result passes from the input register through the scan logic into the result register.
// Reset is synchronous on aresetn low and clears the string state and both valid flags.
// A stalled result holds back the next last byte and the bytes behind it; earlier bytes keep flowing.
module css_color_string_parser_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_byte,
    input  logic       s_last,
    input  logic [7:0] s_fallback_red,
    input  logic [7:0] s_fallback_green,
    input  logic [7:0] s_fallback_blue,
    input  logic [7:0] s_fallback_alpha,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue,
    output logic [7:0] m_alpha,
    output logic [1:0] m_source
);
    import cssp_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    out_busy;
    result_t result;
    result_t m_result;

    assign s_item = '{
        char_byte:      s_char_byte,
        last:           s_last,
        fallback_red:   s_fallback_red,
        fallback_green: s_fallback_green,
        fallback_blue:  s_fallback_blue,
        fallback_alpha: s_fallback_alpha
    };

    assign advance = item_valid && (!item.last || !out_busy);

    cssp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cssp_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    cssp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && item.last),
        .result   (result),
        .busy     (out_busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_red    = m_result.red;
    assign m_green  = m_result.green;
    assign m_blue   = m_result.blue;
    assign m_alpha  = m_result.alpha;
    assign m_source = m_result.source;
endmodule

>>> rtl/core/cssp_checker.sv
// Port-level checks for the CSS color string parser, bound to the top level.
// Depends on cssp_pkg for source codes and on css_color_string_parser_unit ports.
module cssp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_char_byte,
    input logic       s_last,
    input logic [7:0] s_fallback_red,
    input logic [7:0] s_fallback_green,
    input logic [7:0] s_fallback_blue,
    input logic [7:0] s_fallback_alpha,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_red,
    input logic [7:0] m_green,
    input logic [7:0] m_blue,
    input logic [7:0] m_alpha,
    input logic [1:0] m_source
);
    import cssp_pkg::*;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
            && $stable(m_blue) && $stable(m_alpha) && $stable(m_source))
        else $error("stalled result beat changed");

    a_parsed_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_source != SRC_FALLBACK |-> m_alpha == OPAQUE)
        else $error("parsed color not opaque");

    a_short_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_source == SRC_SHORT_HEX |->
            m_red[7:4] == m_red[3:0] && m_green[7:4] == m_green[3:0]
            && m_blue[7:4] == m_blue[3:0])
        else $error("short hex component not a repeated digit");

    a_named_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_source == SRC_NAMED |->
            (m_red == 8'h00 && m_green == 8'h00 && m_blue == 8'h00)
            || (m_red == 8'hFF && m_green == 8'hFF && m_blue == 8'hFF)
            || (m_red == 8'hFF && m_green == 8'h00 && m_blue == 8'h00)
            || (m_red == 8'h00 && m_green == 8'h00 && m_blue == 8'hFF))
        else $error("named color outside the name table");
endmodule

bind css_color_string_parser_unit cssp_checker u_cssp_checker (.*);
